/* rtl/bfft_pkg.sv */
`timescale 1ns / 1ps

package bfft_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 16;
    localparam int SIZE_BITS     = 8;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((SIZE_BITS + ADDR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + ADDR_BITS + 7) / 8) * 8;

    localparam logic OP_RELEASE = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_DUP   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic                 operation;
        logic [SIZE_BITS-1:0] block_size;
        logic [ADDR_BITS-1:0] block_address;
    } item_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [ADDR_BITS-1:0] addr;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t              status;
        logic [ADDR_BITS-1:0] granted_address;
    } result_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
    } ram_req_t;

endpackage

/* rtl/bfft_ram.sv */
`timescale 1ns / 1ps

module bfft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bfft_ctrl.sv */
`timescale 1ns / 1ps

module bfft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfft_pkg::item_t   in_item,
    output bfft_pkg::ram_req_t ram_req,
    input  bfft_pkg::entry_t  ram_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output bfft_pkg::result_t res
);
    import bfft_pkg::*;

    state_t                   state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     chk_vld_reg, chk_vld_next;

    item_t                    item_reg, item_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     issue_done_reg, issue_done_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                     dup_reg, dup_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     best_found_reg, best_found_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]     best_size_reg, best_size_next;
    logic [ADDR_BITS-1:0]     best_addr_reg, best_addr_next;

    logic                     live;

    assign live = valid_reg[chk_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        rd_idx_reg     <= rd_idx_next;
        issue_done_reg <= issue_done_next;
        chk_idx_reg    <= chk_idx_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        best_addr_reg  <= best_addr_next;
    end

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        chk_vld_next    = 1'b0;
        item_next       = item_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        chk_idx_next    = chk_idx_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        best_addr_next  = best_addr_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '{status: STAT_OK, granted_address: '0};
        ram_req   = '{re: 1'b0, raddr: rd_idx_reg, we: 1'b0, waddr: free_idx_reg,
                      wdata: '{size: item_reg.block_size, addr: item_reg.block_address}};

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next       = in_item;
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Read stage: one entry per cycle.
                ram_req.re   = !issue_done_reg;
                chk_vld_next = !issue_done_reg;
                chk_idx_next = rd_idx_reg;
                if (!issue_done_reg) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end

                // Check stage: read data of the entry issued last cycle.
                if (chk_vld_reg) begin
                    if (item_reg.operation == OP_RELEASE) begin
                        if (live && ram_rdata.addr == item_reg.block_address) begin
                            dup_next = 1'b1;
                        end
                        if (!live && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end else begin
                        if (live && ram_rdata.size >= item_reg.block_size &&
                            (!best_found_reg || ram_rdata.size < best_size_reg)) begin
                            best_found_next = 1'b1;
                            best_idx_next   = chk_idx_reg;
                            best_size_next  = ram_rdata.size;
                            best_addr_next  = ram_rdata.addr;
                        end
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_COMMIT: begin
                res_valid = 1'b1;
                if (item_reg.operation == OP_REQUEST) begin
                    if (best_found_reg) begin
                        res.granted_address = best_addr_reg;
                    end else begin
                        res.status = STAT_NOFIT;
                    end
                end else begin
                    priority if (item_reg.block_size == '0) begin
                        res.status = STAT_OK;
                    end else if (dup_reg) begin
                        res.status = STAT_DUP;
                    end else if (!free_found_reg) begin
                        res.status = STAT_FULL;
                    end else begin
                        res.status = STAT_OK;
                    end
                end

                if (res_ready) begin
                    if (item_reg.operation == OP_REQUEST) begin
                        if (best_found_reg) begin
                            valid_next[best_idx_reg] = 1'b0;
                        end
                    end else if (item_reg.block_size != '0 && !dup_reg && free_found_reg) begin
                        ram_req.we                = 1'b1;
                        valid_next[free_idx_reg]  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The live set changes only when an item commits.
    a_valid_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_COMMIT |=> $stable(valid_reg))
        else $error("live entries changed outside commit");

    // At most one entry enters or leaves per item.
    a_one_change: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(valid_reg ^ $past(valid_reg)) <= 1))
        else $error("more than one entry changed in one cycle");

    // A granted entry is big enough and still live at grant time.
    a_grant_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMMIT && item_reg.operation == OP_REQUEST && best_found_reg |->
        best_size_reg >= item_reg.block_size && valid_reg[best_idx_reg])
        else $error("grant of an entry that does not fit");

    // A release only writes into a slot that is empty.
    a_store_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> !valid_reg[ram_req.waddr])
        else $error("release overwrote a live entry");

endmodule

/* rtl/best_fit_free_block_table.sv */
`timescale 1ns / 1ps
// Each item is checked by a scan of the table through the single read port of the entry
// memory, one entry per cycle, plus check and commit; m_tvalid comes from the output
// register that takes the result at commit. A new item is not taken until the current
// one has committed.
// Reset (aresetn low, synchronous) marks every slot empty and drops any result in flight;
// the entry memory itself is not cleared, since an empty slot is never read for its data.

module best_fit_free_block_table (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfft_pkg::S_TDATA_W-1:0] s_tdata,  // block_size, block_address
    input  logic [0:0]                     s_tuser,  // operation

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bfft_pkg::M_TDATA_W-1:0] m_tdata   // status, granted_address, zero pad
);
    import bfft_pkg::*;

    item_t    in_item;
    ram_req_t ram_req;
    entry_t   ram_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    // Output register: holds a finished result so the engine can move on
    // to the next item while the downstream side stalls.
    logic     out_vld_reg;
    result_t  out_data_reg;

    // Unpack the input transfer: size in the low byte, address above it.
    assign in_item.operation     = s_tuser[0];
    assign in_item.block_size    = s_tdata[SIZE_BITS-1:0];
    assign in_item.block_address = s_tdata[SIZE_BITS +: ADDR_BITS];

    // The table entries (size and address) live in one synchronous memory;
    // the liveness of each slot is kept in flip-flops inside the controller.
    bfft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Scan and commit sequencer.
    bfft_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The controller may hand over a result whenever the register is empty
    // or is being drained in the same cycle.
    assign res_ready = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'({out_data_reg.granted_address, out_data_reg.status});

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bfft_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 3 + 12;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STARVED,
        RX_PERIODIC
    } rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    always #5 aclk = ~aclk;

    best_fit_free_block_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Items waiting to be driven, and the results the table must still produce.
    item_t   pending_items[$];
    result_t expected_results[$];

    // Shadow copy of the free table, kept in step with accepted transfers.
    logic [SIZE_BITS-1:0] shadow_size [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] shadow_addr [TABLE_ENTRIES];

    int unsigned issued_count   = 0;
    int unsigned taken_count    = 0;
    int unsigned result_count   = 0;
    int unsigned mismatch_count = 0;
    int unsigned watchdog_count = 0;
    int unsigned status_seen [4];

    // Applies one item to the shadow table and returns the result it must cause.
    function automatic result_t release_or_grant(item_t it);
        result_t r;
        int      best;
        bit      found;
        r.status          = STAT_OK;
        r.granted_address = '0;
        best              = 0;
        found             = 1'b0;
        if (it.operation == OP_RELEASE) begin
            // A zero-size release would leave its slot empty, so it is a no-op.
            if (it.block_size != 0) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (shadow_size[i] != 0 && shadow_addr[i] == it.block_address)
                        found = 1'b1;
                end
                if (found) begin
                    r.status = STAT_DUP;
                end else begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!found && shadow_size[i] == 0) begin
                            shadow_size[i] = it.block_size;
                            shadow_addr[i] = it.block_address;
                            found          = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = STAT_FULL;
                end
            end
        end else begin
            // Strictly smaller wins, so on a tie the lowest index stays.
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (shadow_size[i] != 0 && shadow_size[i] >= it.block_size &&
                    (!found || shadow_size[i] < shadow_size[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                shadow_size[best] = '0;
                r.granted_address = shadow_addr[best];
            end else begin
                r.status = STAT_NOFIT;
            end
        end
        return r;
    endfunction

    task automatic add_item(logic op, logic [SIZE_BITS-1:0] size,
                            logic [ADDR_BITS-1:0] addr);
        item_t it;
        it.operation     = op;
        it.block_size    = size;
        it.block_address = addr;
        pending_items.push_back(it);
    endtask

    // Sender: bursts of random length separated by random gaps. An item stays
    // on the bus until the monitor has counted its transfer.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        item_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && taken_count != issued_count) begin
            // Still waiting for the transfer of the current item.
        end else if (gap_left != 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            s_tdata   <= S_TDATA_W'({next_item.block_address, next_item.block_size});
            s_tuser   <= next_item.operation;
            s_tvalid  <= 1'b1;
            issued_count++;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: switches at random between stall patterns.
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    logic [7:0]  rx_tick = '0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_STARVED: m_tready <= ($urandom_range(0, 5) == 0);
            default:    m_tready <= (rx_tick[4:2] != 3'b000);
        endcase
    end

    // Monitor: predicts on every input transfer, checks every result transfer.
    always @(posedge aclk) begin
        item_t   in_item;
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_item.operation     = s_tuser[0];
                in_item.block_size    = s_tdata[0 +: SIZE_BITS];
                in_item.block_address = s_tdata[SIZE_BITS +: ADDR_BITS];
                expected_results.push_back(release_or_grant(in_item));
                taken_count++;
            end
            if (m_tvalid && m_tready) begin
                got.status          = status_t'(m_tdata[1:0]);
                got.granted_address = m_tdata[2 +: ADDR_BITS];
                result_count++;
                status_seen[got.status]++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: status %0d address %h",
                                 $time, got.status, got.granted_address);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status ||
                        got.granted_address !== want.granted_address) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("[%0t] result %0d: expected %0d/%h, got %0d/%h",
                                     $time, result_count,
                                     want.status, want.granted_address,
                                     got.status, got.granted_address);
                    end
                end
            end
        end
    end

    // Watchdog: ends a run in which no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            watchdog_count <= 0;
        end else if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles, %0d results still due.",
                     watchdog_count, expected_results.size());
            $display("FAIL");
            $finish;
        end else begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    initial begin
        logic [ADDR_BITS-1:0] addr_pool [16];
        int unsigned          phase_left;
        int unsigned          release_pct;
        int unsigned          pick;
        logic                 op;
        logic [SIZE_BITS-1:0] size;
        logic [ADDR_BITS-1:0] addr;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_size[i] = '0;
            shadow_addr[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;

        // Directed part: empty table, zero sizes, extremes, duplicates,
        // full table and a tie between equal sizes.
        add_item(OP_REQUEST, 8'd0,   16'h0000);   // nothing to grant on an empty table
        add_item(OP_RELEASE, 8'd0,   16'h1234);   // zero-size release changes nothing
        add_item(OP_RELEASE, 8'd255, 16'hFFFF);
        add_item(OP_RELEASE, 8'd1,   16'h0000);
        add_item(OP_RELEASE, 8'd7,   16'hFFFF);   // same address, different size
        add_item(OP_REQUEST, 8'd0,   16'hA5A5);   // zero-size request takes the smallest
        add_item(OP_REQUEST, 8'd255, 16'h0000);
        add_item(OP_REQUEST, 8'd1,   16'h0000);   // table is empty again
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            case (i % 4)
                0:       size = 8'd40;
                3:       size = 8'd60;
                default: size = 8'd25;
            endcase
            add_item(OP_RELEASE, size, ADDR_BITS'(16'h0100 + i));
        end
        add_item(OP_RELEASE, 8'd9,  16'h0F00);    // no empty slot left
        add_item(OP_REQUEST, 8'd20, 16'h0000);    // several 25s tie, lowest slot wins

        // Random part: phases that lean toward filling or draining the table,
        // with addresses often reused so that duplicates and full tables occur.
        foreach (addr_pool[i])
            addr_pool[i] = ADDR_BITS'($urandom);
        phase_left  = 0;
        release_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 120);
                case ($urandom_range(0, 2))
                    0:       release_pct = 85;
                    1:       release_pct = 50;
                    default: release_pct = 20;
                endcase
            end
            phase_left--;
            op   = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_REQUEST;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                size = 8'd0;
            else if (pick == 1)
                size = 8'd255;
            else if (pick < 10)
                size = SIZE_BITS'($urandom_range(1, 16));
            else
                size = SIZE_BITS'($urandom);
            if ($urandom_range(0, 99) < 60)
                addr = addr_pool[$urandom_range(0, 15)];
            else
                addr = ADDR_BITS'($urandom);
            add_item(op, size, addr);
        end

        // Reset is held low from the start and released on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0d expected results never arrived.", expected_results.size());
        end
        if (mismatch_count > MAX_REPORTS)
            $display("%0d mismatches in total, only the first %0d shown.",
                     mismatch_count, MAX_REPORTS);

        $display("Covered %0d item transfers and %0d result transfers.",
                 taken_count, result_count);
        $display("Results by status: ok %0d, no fit %0d, duplicate %0d, table full %0d.",
                 status_seen[STAT_OK], status_seen[STAT_NOFIT],
                 status_seen[STAT_DUP], status_seen[STAT_FULL]);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* best_fit_free_block_table.f */
rtl/bfft_pkg.sv
rtl/bfft_ram.sv
rtl/bfft_ctrl.sv
rtl/best_fit_free_block_table.sv
test/tb_top.sv
